>>> hw/rtl/cmm_pkg.sv
// Shared types and constants of the complex matrix multiplier.
package cmm_pkg;

  localparam int ELEM_W    = 16;
  localparam int WORD_W    = 2 * ELEM_W;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int ACC_W     = 36;
  localparam int COORD_W   = 3;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

  localparam logic ACT_ELEM_A = 1'b0;
  localparam logic ACT_ELEM_B = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT
  } cmm_state_t;

  typedef struct packed {
    logic               wr_a;
    logic               wr_b;
    logic               rd_en;
    logic               rd_first;
    logic               rd_last;
    logic               load_out;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic               out_last;
  } cmm_cmd_t;

  typedef struct packed {
    logic acc_done;
    logic out_free;
  } cmm_stat_t;

endpackage

>>> hw/rtl/cmm_in_if.sv
// Input channel: one matrix element per item, tagged by action.
interface cmm_in_if import cmm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic signed [ELEM_W-1:0] elem_real;
  logic signed [ELEM_W-1:0] elem_imag;

  modport source (output valid, action, elem_real, elem_imag, input ready);
  modport sink (input valid, action, elem_real, elem_imag, output ready);
endinterface

>>> hw/rtl/cmm_out_if.sv
// Output channel: one product element per item with its coordinates.
interface cmm_out_if import cmm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ACC_W-1:0]  prod_real;
  logic signed [ACC_W-1:0]  prod_imag;
  logic [COORD_W-1:0]       out_row;
  logic [COORD_W-1:0]       out_col;
  logic                     last;

  modport source (output valid, prod_real, prod_imag, out_row, out_col, last, input ready);
  modport sink (input valid, prod_real, prod_imag, out_row, out_col, last, output ready);
endinterface

>>> hw/rtl/cmm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/cmm_datapath.sv
// Element stores, complex multiply-accumulate pipeline and output register.
module cmm_datapath import cmm_pkg::*; #(
  parameter int MAX_DIM = 8,
  localparam int DEPTH = MAX_DIM * MAX_DIM,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cmm_cmd_t                 cmd,
  input  logic [AW-1:0]            wr_addr,
  input  logic [AW-1:0]            rd_addr_a,
  input  logic [AW-1:0]            rd_addr_b,
  input  logic signed [ELEM_W-1:0] elem_real,
  input  logic signed [ELEM_W-1:0] elem_imag,
  output cmm_stat_t                stat,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [ACC_W-1:0]  prod_real,
  output logic signed [ACC_W-1:0]  prod_imag,
  output logic [COORD_W-1:0]       out_row,
  output logic [COORD_W-1:0]       out_col,
  output logic                     out_last
);

  logic [WORD_W-1:0]        wdata;
  logic [WORD_W-1:0]        a_word;
  logic [WORD_W-1:0]        b_word;
  logic                     v1, first1, last1;
  logic                     v2, first2, last2;
  logic signed [PROD_W-1:0] pr_rr, pr_ii, pr_ri, pr_ir;
  logic signed [ACC_W-1:0]  term_re, term_im;
  logic signed [ACC_W-1:0]  acc_re, acc_im;
  logic                     acc_done;

  assign wdata = {elem_real, elem_imag};

  cmm_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_store_a (
    .clk   (clk),
    .we    (cmd.wr_a),
    .waddr (wr_addr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (rd_addr_a),
    .rdata (a_word)
  );

  cmm_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_store_b (
    .clk   (clk),
    .we    (cmd.wr_b),
    .waddr (wr_addr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (rd_addr_b),
    .rdata (b_word)
  );

  // Stage tags follow the read data through the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.rd_en;
      v2 <= v1;
    end
    first1 <= cmd.rd_first;
    last1  <= cmd.rd_last;
    first2 <= first1;
    last2  <= last1;
  end

  // Four partial products, each registered.
  always_ff @(posedge clk) begin
    if (v1) begin
      pr_rr <= $signed(a_word[WORD_W-1:ELEM_W]) * $signed(b_word[WORD_W-1:ELEM_W]);
      pr_ii <= $signed(a_word[ELEM_W-1:0]) * $signed(b_word[ELEM_W-1:0]);
      pr_ri <= $signed(a_word[WORD_W-1:ELEM_W]) * $signed(b_word[ELEM_W-1:0]);
      pr_ir <= $signed(a_word[ELEM_W-1:0]) * $signed(b_word[WORD_W-1:ELEM_W]);
    end
  end

  assign term_re = ACC_W'(pr_rr) - ACC_W'(pr_ii);
  assign term_im = ACC_W'(pr_ri) + ACC_W'(pr_ir);

  always_ff @(posedge clk) begin
    if (v2) begin
      acc_re <= (first2 ? '0 : acc_re) + term_re;
      acc_im <= (first2 ? '0 : acc_im) + term_im;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_done <= 1'b0;
    end else if (v2 && last2) begin
      acc_done <= 1'b1;
    end else if (cmd.load_out) begin
      acc_done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      prod_real <= acc_re;
      prod_imag <= acc_im;
      out_row   <= cmd.out_row;
      out_col   <= cmd.out_col;
      out_last  <= cmd.out_last;
    end
  end

  assign stat.acc_done = acc_done;
  assign stat.out_free = !out_valid || out_ready;

endmodule

>>> hw/rtl/cmm_ctrl.sv
// Controller: configuration registers, load counters and product sequencer.
module cmm_ctrl import cmm_pkg::*; #(
  parameter int MAX_DIM = 8,
  localparam int DEPTH = MAX_DIM * MAX_DIM,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  localparam int DW = $clog2(MAX_DIM + 1),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_action,
  output logic                 in_ready,
  input  cmm_stat_t            stat,
  output cmm_cmd_t             cmd,
  output logic [AW-1:0]        wr_addr,
  output logic [AW-1:0]        rd_addr_a,
  output logic [AW-1:0]        rd_addr_b
);

  cmm_state_t       state, state_next;
  logic [CFG_W-1:0] rows_a, inner_dim, cols_b;
  logic [CW-1:0]    count_a, count_a_next;
  logic [CW-1:0]    count_b, count_b_next;
  logic [IW-1:0]    row_i, row_i_next;
  logic [IW-1:0]    col_j, col_j_next;
  logic [IW-1:0]    k_idx, k_idx_next;
  logic [AW-1:0]    a_base, a_base_next;
  logic [AW-1:0]    a_addr, a_addr_next;
  logic [AW-1:0]    b_addr, b_addr_next;
  logic [DW-1:0]    m_c, n_c, p_c;
  logic [CW-1:0]    size_a, size_b;
  logic             cfg_hit;
  logic             accept;
  logic             k_last, i_last, j_last;

  function automatic logic [DW-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    if (v == '0) begin
      return DW'(1);
    end else if (int'(v) > MAX_DIM) begin
      return DW'(MAX_DIM);
    end else begin
      return DW'(v);
    end
  endfunction

  assign m_c    = clamp_dim(rows_a);
  assign n_c    = clamp_dim(inner_dim);
  assign p_c    = clamp_dim(cols_b);
  assign size_a = CW'(m_c) * CW'(n_c);
  assign size_b = CW'(n_c) * CW'(p_c);

  assign cfg_hit = cfg_we && (cfg_index == REG_ROWS_A || cfg_index == REG_INNER_DIM ||
                              cfg_index == REG_COLS_B);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= CFG_W'(2);
      inner_dim <= CFG_W'(2);
      cols_b    <= CFG_W'(2);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROWS_A:    rows_a    <= cfg_data;
        REG_INNER_DIM: inner_dim <= cfg_data;
        REG_COLS_B:    cols_b    <= cfg_data;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count_a <= '0;
      count_b <= '0;
      row_i   <= '0;
      col_j   <= '0;
      k_idx   <= '0;
      a_base  <= '0;
      a_addr  <= '0;
      b_addr  <= '0;
    end else begin
      state   <= state_next;
      count_a <= count_a_next;
      count_b <= count_b_next;
      row_i   <= row_i_next;
      col_j   <= col_j_next;
      k_idx   <= k_idx_next;
      a_base  <= a_base_next;
      a_addr  <= a_addr_next;
      b_addr  <= b_addr_next;
    end
  end

  assign accept = in_valid && in_ready;
  assign k_last = (DW'(k_idx) == n_c - DW'(1));
  assign i_last = (DW'(row_i) == m_c - DW'(1));
  assign j_last = (DW'(col_j) == p_c - DW'(1));

  assign wr_addr   = (in_action == ACT_ELEM_B) ? count_b[AW-1:0] : count_a[AW-1:0];
  assign rd_addr_a = a_addr;
  assign rd_addr_b = b_addr;

  always_comb begin
    state_next   = state;
    count_a_next = count_a;
    count_b_next = count_b;
    row_i_next   = row_i;
    col_j_next   = col_j;
    k_idx_next   = k_idx;
    a_base_next  = a_base;
    a_addr_next  = a_addr;
    b_addr_next  = b_addr;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.out_row  = COORD_W'(row_i);
    cmd.out_col  = COORD_W'(col_j);
    cmd.out_last = i_last && j_last;

    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept && in_action == ACT_ELEM_A && count_a < size_a) begin
          cmd.wr_a     = 1'b1;
          count_a_next = CW'(count_a + CW'(1));
        end
        if (accept && in_action == ACT_ELEM_B && count_b < size_b) begin
          cmd.wr_b     = 1'b1;
          count_b_next = CW'(count_b + CW'(1));
          if (CW'(count_b + CW'(1)) == size_b) begin
            // B is complete: clear the counters and start the first product element.
            state_next   = ST_ISSUE;
            count_a_next = '0;
            count_b_next = '0;
            row_i_next   = '0;
            col_j_next   = '0;
            k_idx_next   = '0;
            a_base_next  = '0;
            a_addr_next  = '0;
            b_addr_next  = '0;
          end
        end
      end
      ST_ISSUE: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_first = (k_idx == '0);
        cmd.rd_last  = k_last;
        k_idx_next   = IW'(k_idx + IW'(1));
        a_addr_next  = AW'(a_addr + AW'(1));
        b_addr_next  = AW'(b_addr + AW'(p_c));
        if (k_last) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (stat.acc_done && stat.out_free) begin
          cmd.load_out = 1'b1;
          k_idx_next   = '0;
          if (j_last) begin
            if (i_last) begin
              state_next = ST_IDLE;
            end else begin
              state_next  = ST_ISSUE;
              row_i_next  = IW'(row_i + IW'(1));
              col_j_next  = '0;
              a_base_next = AW'(a_base + AW'(n_c));
              a_addr_next = AW'(a_base + AW'(n_c));
              b_addr_next = '0;
            end
          end else begin
            state_next  = ST_ISSUE;
            col_j_next  = IW'(col_j + IW'(1));
            a_addr_next = a_base;
            b_addr_next = AW'(AW'(col_j) + AW'(1));
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // A register write starts a new load; the stored elements stay.
    if (cfg_hit) begin
      count_a_next = '0;
      count_b_next = '0;
    end
  end

endmodule

>>> hw/rtl/complex_matrix_multiply.sv
// Load: one item per cycle while idle; A and B elements are written to their stores as they arrive.
// Compute: after the item that completes B, each product element runs on the single complex
// multiply-accumulate unit (one store read per cycle, then multiply and accumulate stages).
// Reset (rst, synchronous) sets all dimensions to 2 and clears both load counters; the
// element stores hold no defined value until written.
module complex_matrix_multiply import cmm_pkg::*; #(
  parameter int MAX_DIM = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  cmm_in_if.sink               in_item,
  cmm_out_if.source            out_item
);

  // Store addresses are wide enough for MAX_DIM * MAX_DIM elements.
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmm_cmd_t      cmd;
  cmm_stat_t     stat;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr_a;
  logic [AW-1:0] rd_addr_b;

  // The controller owns the dimension registers, the load counters and the
  // row, column and inner-index sequencing. It takes input items only while
  // idle, so items arriving during a product computation wait.
  cmm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_item.valid),
    .in_action (in_item.action),
    .in_ready  (in_item.ready),
    .stat      (stat),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b)
  );

  // The datapath holds both element stores, the multiply-accumulate pipeline
  // and the output register. The output register lets the next load begin
  // while the last product item still waits to be taken.
  cmm_datapath #(.MAX_DIM(MAX_DIM)) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .elem_real (in_item.elem_real),
    .elem_imag (in_item.elem_imag),
    .stat      (stat),
    .out_valid (out_item.valid),
    .out_ready (out_item.ready),
    .prod_real (out_item.prod_real),
    .prod_imag (out_item.prod_imag),
    .out_row   (out_item.out_row),
    .out_col   (out_item.out_col),
    .out_last  (out_item.last)
  );

endmodule
